// File: sv/flight_event_window_detector_macros.svh
// assertion macros used by the detector module
`ifndef FLIGHT_EVENT_WINDOW_DETECTOR_MACROS_SVH
`define FLIGHT_EVENT_WINDOW_DETECTOR_MACROS_SVH

// property that must hold every cycle out of reset
`define FEWD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define FEWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fewd_pkg.sv
// ----------------------------------------------------------------------------
// fewd_pkg
// shared constants and types of the flight event window detector
// ----------------------------------------------------------------------------
package fewd_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_RANGE_CHECK = 3'd0;
  localparam logic [2:0] REG_EVENT_MODE  = 3'd1;
  localparam logic [2:0] REG_VALID_LIMIT = 3'd2;
  localparam logic [2:0] REG_DROGUE      = 3'd3;
  localparam logic [2:0] REG_MAIN        = 3'd4;
  localparam logic [2:0] REG_DROP        = 3'd5;

  // event modes
  localparam logic [1:0] MODE_PHASES   = 2'd0;
  localparam logic [1:0] MODE_MECO_NEG = 2'd1;
  localparam logic [1:0] MODE_MECO_DROP = 2'd2;

  localparam logic [30:0] VALID_LIMIT_RST = 31'd131072000;
  localparam logic [30:0] DROGUE_RST      = 31'd54067200;
  localparam logic [30:0] MAIN_RST        = 31'd63897600;
  localparam logic signed [31:0] DROP_RST = -32'sd16220;

  typedef struct packed {
    logic        event_detected;
    logic [1:0]  flight_phase;
    logic [31:0] combined_mean;
    logic [31:0] latest_slope;
    logic        windows_full;
  } fewd_result_t;

  typedef struct packed {
    logic [31:0] first_sample;
    logic        first_invalid;
    logic [31:0] second_sample;
    logic        second_invalid;
  } fewd_item_t;

endpackage

// File: sv/fewd_if.sv
// ----------------------------------------------------------------------------
// fewd_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface fewd_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/fewd_div.sv
// ----------------------------------------------------------------------------
// fewd_div
// signed restoring divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
module fewd_div
  import fewd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] num,
  input  logic [5:0]         den,
  output logic               done,
  output logic signed [39:0] quo
);

  logic [39:0] rem_r, rem_nxt, q_r, q_nxt;
  logic        neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [40:0] trial;
  logic [39:0] mag;

  // magnitude of the dividend
  assign mag = num[39] ? 40'(-num) : 40'(num);
  assign trial = {rem_r, q_r[39]} - {35'd0, den};

  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; neg_nxt = neg_r;
    busy_nxt = busy_r; cnt_nxt = cnt_r; done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0; q_nxt = mag; neg_nxt = num[39];
      busy_nxt = 1'b1; cnt_nxt = 6'd40;
    end else if (busy_r) begin
      // one shift-subtract step
      if (!trial[40]) begin
        rem_nxt = trial[39:0];
        q_nxt = {q_r[38:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[38:0], q_r[39]};
        q_nxt = {q_r[38:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; q_r <= q_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo = neg_r ? 40'(-q_r) : q_r;

endmodule

// File: sv/flight_event_window_detector.sv
// ----------------------------------------------------------------------------
// flight_event_window_detector
// windowed two-sensor averaging with slope and 80% vote event detection
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_      in   first/second sample (Q15.16) and invalid flags
// out_     out  event flag, phase, combined mean, latest slope, full flag
// cfg_     in   write enable, register index, 32-bit write data
//
// the time one word takes grows with the window fill and with result stalls:
// window sums step one entry a cycle through a shared adder, up to five
// divisions share one bit-serial divider, and halving the mean sum is a shift.
// synchronous active-low reset clears the counters and phase and loads the
// configuration defaults. ready is low from acceptance until the result word
// is taken; a stalled result holds.
`include "flight_event_window_detector_macros.svh"
module flight_event_window_detector
  import fewd_pkg::*;
#(
  parameter int WINDOW = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  fewd_if.sink        in_ch,
  fewd_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int VOTE = (WINDOW * 4 + 4) / 5;

  // states
  localparam logic [3:0] S_IDLE = 4'd0, S_SUMA = 4'd1, S_DIVA = 4'd2,
    S_SUMB = 4'd3, S_DIVB = 4'd4, S_WRS = 4'd5, S_SUM1 = 4'd6, S_DIV1 = 4'd7,
    S_SUM2 = 4'd8, S_DIV2 = 4'd9, S_SLP = 4'd11,
    S_DIVS = 4'd12, S_VOTE = 4'd13, S_OUT = 4'd14;

  // configuration
  logic        range_r;
  logic [1:0]  mode_r;
  logic [30:0] limit_r, drogue_r, main_r;
  logic signed [31:0] drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= 1'b1; mode_r <= MODE_PHASES; limit_r <= VALID_LIMIT_RST;
      drogue_r <= DROGUE_RST; main_r <= MAIN_RST; drop_r <= DROP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_CHECK: range_r <= cfg_wdata[0];
        REG_EVENT_MODE:  mode_r <= cfg_wdata[1:0];
        REG_VALID_LIMIT: limit_r <= cfg_wdata[30:0];
        REG_DROGUE:      drogue_r <= cfg_wdata[30:0];
        REG_MAIN:        main_r <= cfg_wdata[30:0];
        REG_DROP:        drop_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window memories
  logic signed [31:0] win1 [WINDOW];
  logic signed [31:0] win2 [WINDOW];
  logic signed [31:0] winm [WINDOW];
  logic signed [31:0] wins [WINDOW];

  logic [3:0]  st_r, st_nxt;
  logic [AW-1:0] pos_r, spos_r, idx_r;
  logic [CW-1:0] fill_r, sfill_r, cnt_r;
  logic [1:0]  phase_r;
  logic [CW-1:0] votes_r;
  fewd_item_t  item_r;
  logic signed [39:0] acc_r;
  logic signed [31:0] a_r, b_r, m1_r, m2_r, cm_r, latest_r;
  logic        adv_r, full_r;
  fewd_result_t res_r;

  // shared divider
  logic               dv_start;
  logic signed [39:0] dv_num;
  logic [5:0]         dv_den;
  logic               dv_done;
  logic signed [39:0] dv_quo;

  fewd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  // average of both window means, halved toward zero
  logic signed [32:0] msum;
  logic signed [31:0] cm_half;
  assign msum = 33'(m1_r) + 33'(signed'(dv_quo[31:0]));
  assign cm_half = 32'((msum + $signed({32'd0, msum[32]})) >>> 1);

  logic [CW-1:0] fill_inc;
  assign fill_inc = (fill_r < CW'(WINDOW)) ? fill_r + CW'(1) : fill_r;

  // bad sample tests
  function automatic logic is_bad(logic signed [31:0] s, logic inv,
                                  logic rc, logic [30:0] lim);
    return inv || (rc && ((s <= 0) || (s >= $signed({1'b0, lim}))));
  endfunction

  logic bad1, bad2;
  assign bad1 = is_bad(item_r.first_sample, item_r.first_invalid, range_r, limit_r);
  assign bad2 = is_bad(item_r.second_sample, item_r.second_invalid, range_r, limit_r);

  logic last_idx;
  logic [CW-1:0] sum_n;
  assign last_idx = (CW'(idx_r) + CW'(1) >= sum_n);

  // vote element selection
  logic signed [31:0] vm, vs;
  logic hit;
  logic slope_on;
  assign vm = winm[idx_r];
  assign vs = wins[idx_r];
  assign slope_on = !(mode_r == MODE_MECO_NEG && phase_r == 2'd0);
  always_comb begin
    hit = 1'b0;
    case (mode_r)
      MODE_PHASES: begin
        case (phase_r)
          2'd0: hit = vs > 0;
          2'd1: hit = 33'(signed'(vm)) > $signed({2'b0, drogue_r});
          2'd2: hit = 33'(signed'(vm)) > $signed({2'b0, main_r});
          default: hit = 1'b0;
        endcase
      end
      MODE_MECO_NEG: hit = vm < 0;
      MODE_MECO_DROP: hit = vs < drop_r;
      default: hit = 1'b0;
    endcase
  end
  logic vote_ok;
  always_comb begin
    vote_ok = 1'b0;
    case (mode_r)
      MODE_PHASES: begin
        case (phase_r)
          2'd0: vote_ok = sfill_r == CW'(WINDOW);
          2'd1, 2'd2: vote_ok = fill_r == CW'(WINDOW);
          default: vote_ok = 1'b0;
        endcase
      end
      MODE_MECO_NEG: vote_ok = phase_r == 2'd0 && fill_r == CW'(WINDOW);
      MODE_MECO_DROP: vote_ok = phase_r == 2'd0 && sfill_r == CW'(WINDOW);
      default: vote_ok = 1'b0;
    endcase
  end

  always_comb begin
    sum_n = fill_r;
    if (st_r == S_SUM1 || st_r == S_SUM2) sum_n = fill_r;
  end

  // sequencer
  logic [AW-1:0] posn;
  assign posn = (pos_r == AW'(WINDOW - 1)) ? '0 : pos_r + AW'(1);
  logic signed [31:0] sum_el;
  always_comb begin
    case (st_r)
      S_SUMA, S_SUM1: sum_el = win1[idx_r];
      default: sum_el = win2[idx_r];
    endcase
  end

  always_comb begin
    st_nxt = st_r; dv_start = 1'b0; dv_num = acc_r; dv_den = 6'(fill_r);
    case (st_r)
      S_IDLE: if (in_ch.valid) st_nxt = S_SUMA;
      S_SUMA: if (!bad1 || fill_r == '0) st_nxt = S_SUMB;
              else if (last_idx) begin st_nxt = S_DIVA; end
      S_DIVA: if (dv_done) st_nxt = S_SUMB;
      S_SUMB: if (!bad2 || fill_r == '0) st_nxt = S_WRS;
              else if (last_idx) st_nxt = S_DIVB;
      S_DIVB: if (dv_done) st_nxt = S_WRS;
      S_WRS:  st_nxt = S_SUM1;
      S_SUM1: if (last_idx) st_nxt = S_DIV1;
      S_DIV1: if (dv_done) st_nxt = S_SUM2;
      S_SUM2: if (last_idx) st_nxt = S_DIV2;
      S_DIV2: if (dv_done) st_nxt = S_SLP;
      S_SLP:  st_nxt = (fill_r == CW'(WINDOW) && slope_on) ? S_DIVS : S_VOTE;
      S_DIVS: if (dv_done) st_nxt = S_VOTE;
      S_VOTE: if (!vote_ok || last_idx) st_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    // divider launch on entry to a division state
    if ((st_r == S_SUMA || st_r == S_SUMB || st_r == S_SUM1 || st_r == S_SUM2)
        && (st_nxt == S_DIVA || st_nxt == S_DIVB || st_nxt == S_DIV1
            || st_nxt == S_DIV2)) begin
      dv_start = 1'b1; dv_num = acc_r + 40'(sum_el);
    end
    // slope launch, the fill count equals the window length here
    if (st_r == S_SLP && st_nxt == S_DIVS) begin
      dv_start = 1'b1;
      dv_num = 40'(cm_r) - 40'(winm[posn]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pos_r <= '0; spos_r <= '0; fill_r <= '0; sfill_r <= '0;
      phase_r <= 2'd0; idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          item_r <= in_ch.data; idx_r <= '0; acc_r <= '0;
        end
        S_SUMA: begin
          a_r <= (bad1 && fill_r == '0) ? '0 : item_r.first_sample;
          if (bad1 && fill_r != '0) begin
            acc_r <= last_idx ? '0 : acc_r + 40'(sum_el);
            idx_r <= last_idx ? '0 : idx_r + AW'(1);
          end
        end
        S_DIVA: if (dv_done) a_r <= dv_quo[31:0];
        S_SUMB: begin
          b_r <= (bad2 && fill_r == '0) ? '0 : item_r.second_sample;
          if (bad2 && fill_r != '0) begin
            acc_r <= last_idx ? '0 : acc_r + 40'(sum_el);
            idx_r <= last_idx ? '0 : idx_r + AW'(1);
          end
        end
        S_DIVB: if (dv_done) b_r <= dv_quo[31:0];
        S_WRS: begin
          win1[pos_r] <= a_r; win2[pos_r] <= b_r; fill_r <= fill_inc;
          acc_r <= '0; idx_r <= '0;
        end
        S_SUM1, S_SUM2: begin
          acc_r <= last_idx ? '0 : acc_r + 40'(sum_el);
          idx_r <= last_idx ? '0 : idx_r + AW'(1);
        end
        S_DIV1: if (dv_done) m1_r <= dv_quo[31:0];
        S_DIV2: if (dv_done) begin
          cm_r <= cm_half; winm[pos_r] <= cm_half;
        end
        S_SLP: begin
          pos_r <= posn; full_r <= fill_r == CW'(WINDOW);
          votes_r <= '0; idx_r <= '0;
        end
        S_DIVS: if (dv_done) begin
          wins[spos_r] <= dv_quo[31:0];
          spos_r <= (spos_r == AW'(WINDOW - 1)) ? '0 : spos_r + AW'(1);
          if (sfill_r < CW'(WINDOW)) sfill_r <= sfill_r + CW'(1);
        end
        S_VOTE: begin
          if (vote_ok) begin
            votes_r <= votes_r + CW'(hit);
            idx_r <= last_idx ? '0 : idx_r + AW'(1);
          end
          if (!vote_ok || last_idx) begin
            adv_r <= vote_ok && (CW'(votes_r + CW'(hit)) >= CW'(VOTE));
            if (vote_ok && (votes_r + CW'(hit) >= CW'(VOTE)))
              phase_r <= phase_r + 2'd1;
            latest_r <= (sfill_r != '0)
              ? wins[(spos_r == '0) ? AW'(WINDOW - 1) : spos_r - AW'(1)] : '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign cnt_r = sfill_r;
  assign res_r = '{event_detected: adv_r, flight_phase: phase_r,
                   combined_mean: cm_r, latest_slope: latest_r,
                   windows_full: full_r};

  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = res_r;

  `FEWD_ASSERT(a_fill_bound, clk, rst_n, fill_r <= CW'(WINDOW), "fill over window")
  `FEWD_ASSERT(a_sfill_le, clk, rst_n, cnt_r <= fill_r, "slope fill over mean fill")
  `FEWD_ASSERT(a_excl, clk, rst_n, !(in_ch.ready && out_ch.valid), "accept while result pending")
  `FEWD_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
    out_ch.valid && $stable(out_ch.data), "result dropped while stalled")

endmodule

// File: sim/tb_flight_event_window_detector.sv
// ----------------------------------------------------------------------------
// tb_flight_event_window_detector
// self-checking bench: directed corner words, then randomised flight profiles
// per event mode with noise and sensor dropouts, random stalls on both
// channels, and a predictor that checks every result word field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_flight_event_window_detector;
  import fewd_pkg::*;

  localparam int WINDOW = 5;
  localparam int HPA = 65536;
  localparam int DRAIN = 400;
  localparam int CYCLE_LIMIT = 2000000;

  // window predictor and store of expected result words
  class fewd_scoreboard;
    bit               range_check;
    logic [1:0]       event_mode;
    longint           valid_limit, drogue_level, main_level, drop_threshold;
    int               sensor_win[2][WINDOW];
    int               mean_win[WINDOW];
    int               slope_win[WINDOW];
    int               wr_pos, fill, slope_pos, slope_fill, phase;
    fewd_result_t     pending_results[$];
    int               errors;

    function new();
      range_check = 1'b1;
      event_mode = MODE_PHASES;
      valid_limit = VALID_LIMIT_RST;
      drogue_level = DROGUE_RST;
      main_level = MAIN_RST;
      drop_threshold = DROP_RST;
      wr_pos = 0; fill = 0; slope_pos = 0; slope_fill = 0; phase = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_RANGE_CHECK: range_check = d[0];
        REG_EVENT_MODE:  event_mode = d[1:0];
        REG_VALID_LIMIT: valid_limit = longint'(d[30:0]);
        REG_DROGUE:      drogue_level = longint'(d[30:0]);
        REG_MAIN:        main_level = longint'(d[30:0]);
        REG_DROP:        drop_threshold = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function longint sensor_mean(int which);
      longint sum;
      sum = 0;
      if (fill == 0) return 0;
      for (int i = 0; i < fill; i++) sum += sensor_win[which][i];
      return sum / fill;
    endfunction

    // flagged or implausible reading falls back to its window mean
    function int screen(int which, logic [31:0] raw, logic inv);
      int  s;
      bit  bad;
      s = $signed(raw);
      bad = inv;
      if (range_check && (s <= 0 || longint'(s) >= valid_limit)) bad = 1'b1;
      return bad ? int'(sensor_mean(which)) : s;
    endfunction

    function bit vote(int count);
      return count * 5 >= WINDOW * 4;
    endfunction

    function bit means_over(longint level);
      int c;
      c = 0;
      if (fill < WINDOW) return 1'b0;
      foreach (mean_win[i]) if (longint'(mean_win[i]) > level) c++;
      return vote(c);
    endfunction

    function bit means_negative();
      int c;
      c = 0;
      if (fill < WINDOW) return 1'b0;
      foreach (mean_win[i]) if (mean_win[i] < 0) c++;
      return vote(c);
    endfunction

    function bit slopes_under(longint level, bit rising);
      int c;
      c = 0;
      if (slope_fill < WINDOW) return 1'b0;
      foreach (slope_win[i])
        if (rising ? slope_win[i] > 0 : longint'(slope_win[i]) < level) c++;
      return vote(c);
    endfunction

    function void note_item(fewd_item_t it);
      int           a, b, cm, latest;
      longint       newest, oldest;
      bit           adv;
      fewd_result_t r;
      a = screen(0, it.first_sample, it.first_invalid);
      b = screen(1, it.second_sample, it.second_invalid);
      sensor_win[0][wr_pos] = a;
      sensor_win[1][wr_pos] = b;
      if (fill < WINDOW) fill++;
      cm = int'((sensor_mean(0) + sensor_mean(1)) / 2);
      mean_win[wr_pos] = cm;
      wr_pos = (wr_pos + 1) % WINDOW;
      // slope over the mean window, skipped while seeking a negative mean
      if (fill >= WINDOW && !(event_mode == MODE_MECO_NEG && phase == 0)) begin
        newest = mean_win[(wr_pos + WINDOW - 1) % WINDOW];
        oldest = mean_win[wr_pos];
        slope_win[slope_pos] = int'((newest - oldest) / WINDOW);
        slope_pos = (slope_pos + 1) % WINDOW;
        if (slope_fill < WINDOW) slope_fill++;
      end
      latest = (slope_fill > 0) ? slope_win[(slope_pos + WINDOW - 1) % WINDOW] : 0;
      adv = 1'b0;
      case (event_mode)
        MODE_PHASES: begin
          if (phase == 0) adv = slopes_under(0, 1'b1);
          else if (phase == 1) adv = means_over(drogue_level);
          else if (phase == 2) adv = means_over(main_level);
        end
        MODE_MECO_NEG:  if (phase == 0) adv = means_negative();
        MODE_MECO_DROP: if (phase == 0) adv = slopes_under(drop_threshold, 1'b0);
        default: ;
      endcase
      if (adv) phase = (phase + 1) & 3;
      r.event_detected = adv;
      r.flight_phase = phase[1:0];
      r.combined_mean = cm;
      r.latest_slope = latest;
      r.windows_full = (fill >= WINDOW);
      pending_results = {pending_results, r};
    endfunction

    function void check_result(fewd_result_t got);
      fewd_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.event_detected !== exp_r.event_detected) begin
        $display("%0t: event_detected expected %0d actual %0d", $time,
                 exp_r.event_detected, got.event_detected);
        errors++;
      end
      if (got.flight_phase !== exp_r.flight_phase) begin
        $display("%0t: flight_phase expected %0d actual %0d", $time,
                 exp_r.flight_phase, got.flight_phase);
        errors++;
      end
      if (got.combined_mean !== exp_r.combined_mean) begin
        $display("%0t: combined_mean expected %0d actual %0d", $time,
                 $signed(exp_r.combined_mean), $signed(got.combined_mean));
        errors++;
      end
      if (got.latest_slope !== exp_r.latest_slope) begin
        $display("%0t: latest_slope expected %0d actual %0d", $time,
                 $signed(exp_r.latest_slope), $signed(got.latest_slope));
        errors++;
      end
      if (got.windows_full !== exp_r.windows_full) begin
        $display("%0t: windows_full expected %0d actual %0d", $time,
                 exp_r.windows_full, got.windows_full);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  fewd_if #(.T(fewd_item_t))   in_ch ();
  fewd_if #(.T(fewd_result_t)) out_ch ();

  fewd_scoreboard sb;
  bit             calm;
  bit             hold_req;
  int             hold_left;
  int             cycles;
  int             words_sent;

  flight_event_window_detector #(.WINDOW(WINDOW)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_flight_event_window_detector NOT OK");
        $finish;
      end
    end
  end

  // result side: check accepted words, random stalls and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 3000;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  // offer one word, hold it until taken, then maybe idle
  task automatic send_word(fewd_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    words_sent++;
    if (!calm && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // wait for every expected word plus a margin before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  function automatic fewd_item_t mk(int s1, bit i1, int s2, bit i2);
    fewd_item_t it;
    it.first_sample = s1;
    it.first_invalid = i1;
    it.second_sample = s2;
    it.second_invalid = i2;
    return it;
  endfunction

  // one noisy reading around the profile, with dropouts and wild values
  function automatic int reading(int p, output bit inv);
    int r;
    inv = 1'b0;
    r = $urandom_range(99);
    if (r < 8) begin
      inv = 1'b1;
      return $urandom;
    end
    if (r < 12) begin
      case ($urandom_range(4))
        0: return 0;
        1: return -1;
        2: return int'(sb.valid_limit);
        3: return 32'h7fffffff;
        default: return $urandom;
      endcase
    end
    return p + $urandom_range(0, 2 * HPA) - HPA;
  endfunction

  // one flight: registers for the mode, then a pressure trend with noise
  task automatic fly(logic [1:0] mode, int n, int idx);
    int p, step, s1, s2;
    bit i1, i2;
    drain();
    write_cfg(REG_EVENT_MODE, {30'd0, mode});
    write_cfg(REG_RANGE_CHECK, (mode == MODE_MECO_NEG) ? 0 : ($urandom_range(7) != 0));
    case ($urandom_range(5))
      0: write_cfg(REG_VALID_LIMIT, 32'h7fffffff);
      1: write_cfg(REG_VALID_LIMIT, $urandom);
      default: write_cfg(REG_VALID_LIMIT, 2000 * HPA);
    endcase
    write_cfg(REG_DROGUE, (idx % 5 == 4) ? 0 : $urandom_range(700, 900) * HPA);
    write_cfg(REG_MAIN, (idx % 7 == 6) ? 32'h7fffffff : $urandom_range(900, 1050) * HPA);
    write_cfg(REG_DROP, (idx % 6 == 5) ? 32'h80000000 : -$urandom_range(0, 5 * HPA));
    case (mode)
      MODE_PHASES: begin
        p = $urandom_range(300, 700) * HPA;
        step = $urandom_range(2, 15) * HPA;
      end
      MODE_MECO_NEG: begin
        p = $urandom_range(10, 80) * HPA;
        step = -$urandom_range(1, 5) * HPA;
      end
      MODE_MECO_DROP: begin
        p = $urandom_range(1200, 1800) * HPA;
        step = -$urandom_range(1, 8) * HPA;
      end
      default: begin
        p = $urandom_range(1, 1900) * HPA;
        step = 0;
      end
    endcase
    if (idx == 2) hold_req = 1'b1;
    for (int k = 0; k < n; k++) begin
      // sender pause until the block has delivered everything
      if (idx == 3 && k == n / 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() > 0) @(posedge clk);
      end
      if (step == 0) p += $urandom_range(0, 40 * HPA) - 20 * HPA;
      else p += step;
      s1 = reading(p, i1);
      s2 = reading(p, i2);
      send_word(mk(s1, i1, s2, i2));
    end
  endtask

  initial begin
    fewd_item_t corner[$];
    int flight;
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    words_sent = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_RANGE_CHECK;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dropout on empty windows, range edges, flag combinations
    corner = '{mk(1000 * HPA, 1, 1000 * HPA, 1), mk(0, 0, -1, 0),
               mk(1, 0, 2000 * HPA - 1, 0), mk(2000 * HPA, 0, 1, 0),
               mk(32'h7fffffff, 0, 32'h80000000, 0), mk(500 * HPA, 1, 600 * HPA, 0),
               mk(700 * HPA, 0, 800 * HPA, 1), mk(900 * HPA, 0, 950 * HPA, 0)};
    foreach (corner[i]) send_word(corner[i]);
    drain();
    write_cfg(REG_RANGE_CHECK, 0);
    write_cfg(REG_VALID_LIMIT, 0);
    write_cfg(REG_EVENT_MODE, 3);
    corner = '{mk(32'h7fffffff, 0, 32'h7fffffff, 0), mk(32'h80000000, 0, 32'h80000000, 0),
               mk(32'h7fffffff, 0, 32'h80000000, 1), mk(0, 1, 32'h7fffffff, 0),
               mk(-1, 0, 1, 0), mk(32'h80000000, 1, 32'h80000000, 1),
               mk(32'h7fffffff, 0, 32'h7fffffff, 0)};
    foreach (corner[i]) send_word(corner[i]);
    drain();
    write_cfg(REG_RANGE_CHECK, 1);
    write_cfg(REG_DROGUE, 32'h7fffffff);
    write_cfg(REG_MAIN, 0);
    write_cfg(REG_DROP, 0);
    corner = '{mk(5, 0, 6, 0), mk(-5, 0, 3, 1), mk(7, 1, 8, 0)};
    foreach (corner[i]) send_word(corner[i]);

    // random flights, each with a randomly drawn event mode; the first draws only a defined mode
    flight = 0;
    while (words_sent < 1000) begin
      calm = (flight == 1);
      if (flight == 0) fly($urandom_range(2), $urandom_range(60, 100), flight);
      else fly($urandom_range(3), $urandom_range(40, 100), flight);
      flight++;
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_flight_event_window_detector OK");
    end else begin
      $display("tb_flight_event_window_detector NOT OK");
    end
    $finish;
  end

endmodule
